// ----- hw/rtl/pcpu_pkg.sv -----
// Shared types, constants and helper functions of the polar/rectangular point unit.
package pcpu_pkg;

    localparam int CORDIC_STEPS_DEF = 24;

    localparam int COORD_W    = 32;
    localparam int WORK_W     = 36;
    localparam int ANG_W      = 34;
    localparam int MUL_W      = 34;
    localparam int PROD_W     = 64;
    localparam int STEP_IDX_W = 5;

    localparam logic [1:0] ACT_SET_RECT  = 2'd0;
    localparam logic [1:0] ACT_SET_POLAR = 2'd1;
    localparam logic [1:0] ACT_TRANSLATE = 2'd2;

    localparam logic signed [ANG_W-1:0] ANG_PI      = ANG_W'(843314857);
    localparam logic signed [ANG_W-1:0] ANG_2PI     = ANG_W'(1686629713);
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(421657428);

    localparam logic [29:0] INV_GAIN = 30'd652032874;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(536870912);

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_VPREP,
        DP_RWRAP,
        DP_RFOLD,
        DP_MUL,
        DP_RINIT,
        DP_ITER,
        DP_VFIN,
        DP_RFIN,
        DP_PUBLISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op                  op;
        logic                    vector;
        logic [STEP_IDX_W-1:0]   step;
    } t_dp_cmd;

    typedef struct packed {
        logic axis;
    } t_dp_status;

    // Clamp a work word to the 32-bit signed range.
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WORK_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if ((&v[WORK_W-1:COORD_W-1]) || !(|v[WORK_W-1:COORD_W-1])) begin
            r = v[COORD_W-1:0];
        end else if (v[WORK_W-1]) begin
            r = COORD_MIN;
        end else begin
            r = COORD_MAX;
        end
        return r;
    endfunction

    // atan(2^-i) in Q6.28, rounded.
    function automatic logic signed [ANG_W-1:0] atan_step(input logic [STEP_IDX_W-1:0] i);
        logic signed [ANG_W-1:0] v;
        case (i)
            5'd0: v = ANG_W'(210828714);
            5'd1: v = ANG_W'(124459457);
            5'd2: v = ANG_W'(65760959);
            5'd3: v = ANG_W'(33381290);
            5'd4: v = ANG_W'(16755422);
            5'd5: v = ANG_W'(8385879);
            5'd6: v = ANG_W'(4193963);
            5'd7: v = ANG_W'(2097109);
            5'd8: v = ANG_W'(1048571);
            5'd9: v = ANG_W'(524287);
            default: begin
                if (i <= 5'd28) begin
                    v = ANG_W'(1) <<< (5'd28 - i);
                end else begin
                    v = '0;
                end
            end
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/pcpu_datapath.sv -----
// Datapath: point registers, shared CORDIC unit, gain multiplier and output registers.
module pcpu_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pcpu_pkg::t_dp_cmd          i_cmd,
    output pcpu_pkg::t_dp_status       o_status,
    input  logic [1:0]                 i_action,
    input  logic signed [31:0]         i_new_x,
    input  logic signed [31:0]         i_new_y,
    input  logic signed [31:0]         i_new_radius,
    input  logic signed [31:0]         i_new_angle,
    input  logic signed [31:0]         i_shift_x,
    input  logic signed [31:0]         i_shift_y,
    output logic signed [31:0]         o_out_x,
    output logic signed [31:0]         o_out_y,
    output logic signed [31:0]         o_out_radius,
    output logic signed [31:0]         o_out_angle
);

    logic signed [pcpu_pkg::COORD_W-1:0] r_px, r_py, r_pr, r_pa;
    logic signed [pcpu_pkg::WORK_W-1:0]  r_wx, r_wy;
    logic signed [pcpu_pkg::ANG_W-1:0]   r_wz;
    logic signed [pcpu_pkg::PROD_W-1:0]  r_prod;
    logic                                r_ovf;

    logic signed [pcpu_pkg::WORK_W-1:0]  w_px_w, w_py_w, w_pr_w;
    logic                                w_x_zero, w_y_zero, w_axis;
    logic signed [pcpu_pkg::COORD_W-1:0] w_axis_r, w_axis_a;
    logic signed [pcpu_pkg::ANG_W-1:0]   w_pa_a;
    logic signed [pcpu_pkg::MUL_W-1:0]   w_mul_a;
    logic signed [pcpu_pkg::PROD_W-1:0]  w_prod, w_rnd;
    logic signed [pcpu_pkg::WORK_W-1:0]  w_rnd_w;
    logic signed [pcpu_pkg::WORK_W-1:0]  w_dx, w_dy;
    logic signed [pcpu_pkg::ANG_W-1:0]   w_at;
    logic                                w_plus;

    assign w_px_w = pcpu_pkg::WORK_W'(r_px);
    assign w_py_w = pcpu_pkg::WORK_W'(r_py);
    assign w_pr_w = pcpu_pkg::WORK_W'(r_pr);
    assign w_pa_a = pcpu_pkg::ANG_W'(r_pa);

    // Points on an axis skip the vectoring iterations.
    assign w_x_zero = (r_px == '0);
    assign w_y_zero = (r_py == '0);
    assign w_axis   = w_x_zero || w_y_zero;
    assign o_status.axis = w_axis;

    always_comb begin
        if (w_y_zero) begin
            w_axis_r = r_px[31] ? pcpu_pkg::sat32(-w_px_w) : r_px;
            w_axis_a = r_px[31] ? pcpu_pkg::ANG_PI[31:0] : '0;
        end else begin
            w_axis_r = r_py[31] ? pcpu_pkg::sat32(-w_py_w) : r_py;
            w_axis_a = r_py[31] ? -pcpu_pkg::ANG_HALF_PI[31:0] : pcpu_pkg::ANG_HALF_PI[31:0];
        end
    end

    // Vectoring scales the clamped magnitude, rotation scales the signed radius.
    always_comb begin
        if (i_cmd.vector) begin
            w_mul_a = r_wx[pcpu_pkg::WORK_W-1] ? '0 : {2'b00, r_wx[31:0]};
        end else begin
            w_mul_a = pcpu_pkg::MUL_W'($signed(r_wx[32:0]));
        end
    end

    assign w_prod  = w_mul_a * $signed({1'b0, pcpu_pkg::INV_GAIN});
    assign w_rnd   = (r_prod + pcpu_pkg::ROUND_HALF) >>> 30;
    assign w_rnd_w = w_rnd[pcpu_pkg::WORK_W-1:0];

    assign w_dx   = r_wy >>> i_cmd.step;
    assign w_dy   = r_wx >>> i_cmd.step;
    assign w_at   = pcpu_pkg::atan_step(i_cmd.step);
    assign w_plus = i_cmd.vector ? !r_wy[pcpu_pkg::WORK_W-1] : r_wz[pcpu_pkg::ANG_W-1];

    // Held point.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0;
            r_py <= '0;
            r_pr <= '0;
            r_pa <= '0;
        end else begin
            case (i_cmd.op)
                pcpu_pkg::DP_LOAD: begin
                    case (i_action)
                        pcpu_pkg::ACT_SET_RECT: begin
                            r_px <= i_new_x;
                            r_py <= i_new_y;
                        end
                        pcpu_pkg::ACT_SET_POLAR: begin
                            r_pr <= i_new_radius;
                            r_pa <= i_new_angle;
                        end
                        pcpu_pkg::ACT_TRANSLATE: begin
                            r_px <= pcpu_pkg::sat32(w_px_w + pcpu_pkg::WORK_W'(i_shift_x));
                            r_py <= pcpu_pkg::sat32(w_py_w + pcpu_pkg::WORK_W'(i_shift_y));
                        end
                        default: ;
                    endcase
                end
                pcpu_pkg::DP_VPREP: begin
                    if (w_axis) begin
                        r_pr <= w_axis_r;
                        r_pa <= w_axis_a;
                    end
                end
                pcpu_pkg::DP_VFIN: begin
                    r_pr <= r_ovf ? pcpu_pkg::COORD_MAX : pcpu_pkg::sat32(w_rnd_w);
                    r_pa <= pcpu_pkg::sat32(pcpu_pkg::WORK_W'(r_wz));
                end
                pcpu_pkg::DP_RFIN: begin
                    r_px <= pcpu_pkg::sat32(r_wx);
                    r_py <= pcpu_pkg::sat32(r_wy);
                end
                default: ;
            endcase
        end
    end

    // Working registers of the CORDIC unit.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            pcpu_pkg::DP_VPREP: begin
                if (r_px[31]) begin
                    r_wx <= -w_px_w;
                    r_wy <= -w_py_w;
                    r_wz <= r_py[31] ? -pcpu_pkg::ANG_PI : pcpu_pkg::ANG_PI;
                end else begin
                    r_wx <= w_px_w;
                    r_wy <= w_py_w;
                    r_wz <= '0;
                end
            end
            pcpu_pkg::DP_RWRAP: begin
                if (w_pa_a > pcpu_pkg::ANG_PI) begin
                    r_wz <= w_pa_a - pcpu_pkg::ANG_2PI;
                end else if (w_pa_a < -pcpu_pkg::ANG_PI) begin
                    r_wz <= w_pa_a + pcpu_pkg::ANG_2PI;
                end else begin
                    r_wz <= w_pa_a;
                end
            end
            pcpu_pkg::DP_RFOLD: begin
                if (r_wz > pcpu_pkg::ANG_HALF_PI) begin
                    r_wz <= r_wz - pcpu_pkg::ANG_PI;
                    r_wx <= -w_pr_w;
                end else if (r_wz < -pcpu_pkg::ANG_HALF_PI) begin
                    r_wz <= r_wz + pcpu_pkg::ANG_PI;
                    r_wx <= -w_pr_w;
                end else begin
                    r_wx <= w_pr_w;
                end
            end
            pcpu_pkg::DP_MUL: begin
                r_prod <= w_prod;
                r_ovf  <= i_cmd.vector && !r_wx[pcpu_pkg::WORK_W-1] && (r_wx[34:32] != '0);
            end
            pcpu_pkg::DP_RINIT: begin
                r_wx <= w_rnd_w;
                r_wy <= '0;
            end
            pcpu_pkg::DP_ITER: begin
                if (w_plus) begin
                    r_wx <= r_wx + w_dx;
                    r_wy <= r_wy - w_dy;
                    r_wz <= r_wz + w_at;
                end else begin
                    r_wx <= r_wx - w_dx;
                    r_wy <= r_wy + w_dy;
                    r_wz <= r_wz - w_at;
                end
            end
            default: ;
        endcase
    end

    // Output beat registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == pcpu_pkg::DP_PUBLISH) begin
            o_out_x      <= r_px;
            o_out_y      <= r_py;
            o_out_radius <= r_pr;
            o_out_angle  <= r_pa;
        end
    end

endmodule

// ----- hw/rtl/pcpu_ctrl.sv -----
// Controller: sequences load, range reduction, CORDIC iterations and output handshake.
module pcpu_ctrl #(
    parameter int CORDIC_STEPS = pcpu_pkg::CORDIC_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_action,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output pcpu_pkg::t_dp_cmd     o_cmd,
    input  pcpu_pkg::t_dp_status  i_status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_VPREP,
        S_RWRAP,
        S_RFOLD,
        S_MUL,
        S_RINIT,
        S_ITER,
        S_VFIN,
        S_RFIN,
        S_DONE
    } t_state;

    t_state                              r_state;
    logic [pcpu_pkg::STEP_IDX_W-1:0]     r_step;
    logic                                r_vector;
    logic                                r_out_valid;

    logic w_accept, w_last, w_publish;

    assign w_accept    = (r_state == S_IDLE) && i_in_valid;
    assign w_last      = (r_step == pcpu_pkg::STEP_IDX_W'(CORDIC_STEPS - 1));
    assign w_publish   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.vector = r_vector;
        o_cmd.step   = r_step;
        case (r_state)
            S_IDLE:  o_cmd.op = w_accept ? pcpu_pkg::DP_LOAD : pcpu_pkg::DP_NOP;
            S_VPREP: o_cmd.op = pcpu_pkg::DP_VPREP;
            S_RWRAP: o_cmd.op = pcpu_pkg::DP_RWRAP;
            S_RFOLD: o_cmd.op = pcpu_pkg::DP_RFOLD;
            S_MUL:   o_cmd.op = pcpu_pkg::DP_MUL;
            S_RINIT: o_cmd.op = pcpu_pkg::DP_RINIT;
            S_ITER:  o_cmd.op = pcpu_pkg::DP_ITER;
            S_VFIN:  o_cmd.op = pcpu_pkg::DP_VFIN;
            S_RFIN:  o_cmd.op = pcpu_pkg::DP_RFIN;
            S_DONE:  o_cmd.op = w_publish ? pcpu_pkg::DP_PUBLISH : pcpu_pkg::DP_NOP;
            default: o_cmd.op = pcpu_pkg::DP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_vector    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_publish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_action)
                            pcpu_pkg::ACT_SET_RECT,
                            pcpu_pkg::ACT_TRANSLATE: begin
                                r_vector <= 1'b1;
                                r_state  <= S_VPREP;
                            end
                            pcpu_pkg::ACT_SET_POLAR: begin
                                r_vector <= 1'b0;
                                r_state  <= S_RWRAP;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_VPREP: r_state <= i_status.axis ? S_DONE : S_ITER;
                S_RWRAP: r_state <= S_RFOLD;
                S_RFOLD: r_state <= S_MUL;
                S_MUL:   r_state <= r_vector ? S_VFIN : S_RINIT;
                S_RINIT: r_state <= S_ITER;
                S_ITER: begin
                    if (w_last) begin
                        r_step  <= '0;
                        r_state <= r_vector ? S_MUL : S_RFIN;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_VFIN:  r_state <= S_DONE;
                S_RFIN:  r_state <= S_DONE;
                S_DONE: begin
                    if (w_publish) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ITER) |-> (r_step == '0))
        else $error("step counter running outside the iteration phase");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == pcpu_pkg::DP_PUBLISH) |-> (!r_out_valid || !i_out_stall))
        else $error("output beat overwritten while stalled");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("accepted beat did not start work");

    a_iter_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ITER && w_last) |=> (r_state == S_MUL || r_state == S_RFIN))
        else $error("iteration phase left to a wrong state");
`endif

endmodule

// ----- hw/rtl/polar_cartesian_point_unit_core.sv -----
// Top level of the polar/rectangular point unit: controller plus datapath.
//
//   channel   direction   handshake                   payload
//   input     in          i_in_valid / o_in_stall     i_action, i_new_*, i_shift_*
//   output    out         o_out_valid / i_out_stall   o_out_x, o_out_y, o_out_radius, o_out_angle
//
// One beat at a time; each beat runs CORDIC_STEPS iterations of one shared CORDIC unit.
// Set rectangular and translate: prep, iterations, gain multiply and round (on an axis, prep alone).
// Set polar: wrap, fold, gain multiply and round precede the iterations.
// Unused action code: no work. The cycle after a beat is published, the next beat is let in.
// Reset (synchronous, active low) clears the held point to zero; no clearing pass.
// A stalled output beat holds the finished result and blocks only the next completion.
module polar_cartesian_point_unit_core #(
    parameter int CORDIC_STEPS = pcpu_pkg::CORDIC_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_action,
    input  logic signed [31:0]  i_new_x,
    input  logic signed [31:0]  i_new_y,
    input  logic signed [31:0]  i_new_radius,
    input  logic signed [31:0]  i_new_angle,
    input  logic signed [31:0]  i_shift_x,
    input  logic signed [31:0]  i_shift_y,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [31:0]  o_out_x,
    output logic signed [31:0]  o_out_y,
    output logic signed [31:0]  o_out_radius,
    output logic signed [31:0]  o_out_angle
);

    pcpu_pkg::t_dp_cmd    w_cmd;
    pcpu_pkg::t_dp_status w_status;

    pcpu_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    pcpu_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_action     (i_action),
        .i_new_x      (i_new_x),
        .i_new_y      (i_new_y),
        .i_new_radius (i_new_radius),
        .i_new_angle  (i_new_angle),
        .i_shift_x    (i_shift_x),
        .i_shift_y    (i_shift_y),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_radius (o_out_radius),
        .o_out_angle  (o_out_angle)
    );

endmodule
